/* hw/rtl/tao_pkg.sv */
// Shared types and codes for the TCP active open/close controller.
// Holds input, result and command codes, the phase encoding and the transfer structs.
// No dependencies.
package tao_pkg;

    localparam int CMD_DEPTH = 2;

    localparam logic [2:0] KIND_OPEN_REQ     = 3'd0;
    localparam logic [2:0] KIND_LOOKUP_REPLY = 3'd1;
    localparam logic [2:0] KIND_FREE_PORT    = 3'd2;
    localparam logic [2:0] KIND_RX_STATUS    = 3'd3;
    localparam logic [2:0] KIND_TIMER_STATUS = 3'd4;
    localparam logic [2:0] KIND_CLOSE_REQ    = 3'd5;
    localparam logic [2:0] KIND_STATE_REPLY  = 3'd6;

    localparam logic [2:0] RES_PORT_REQ    = 3'd0;
    localparam logic [2:0] RES_LOOKUP_REQ  = 3'd1;
    localparam logic [2:0] RES_OPEN_STATUS = 3'd2;
    localparam logic [2:0] RES_EVENT       = 3'd3;
    localparam logic [2:0] RES_STATE_REQ   = 3'd4;
    localparam logic [2:0] RES_REFUSED     = 3'd5;

    localparam logic [2:0] CMD_PORT_REQ = 3'd0;
    localparam logic [2:0] CMD_LOOKUP   = 3'd1;
    localparam logic [2:0] CMD_STATUS   = 3'd2;
    localparam logic [2:0] CMD_SYN      = 3'd3;
    localparam logic [2:0] CMD_CLOSE_RD = 3'd4;
    localparam logic [2:0] CMD_CLOSE_WR = 3'd5;
    localparam logic [2:0] CMD_REFUSE   = 3'd6;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PORT  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;

    localparam logic [3:0] ST_SYN_SENT    = 4'd1;
    localparam logic [3:0] ST_ESTABLISHED = 4'd3;
    localparam logic [3:0] ST_FIN_WAIT_1  = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT_2  = 4'd5;

    localparam logic EVT_SYN = 1'b0;
    localparam logic EVT_FIN = 1'b1;

    typedef struct packed {
        logic [2:0]  code;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic [15:0] port;
        logic [15:0] session;
        logic        success;
        logic [3:0]  state;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic [15:0] session;
        logic        success;
        logic        event_type;
        logic        state_write;
        logic [3:0]  state_value;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] phase;
    } front_status_t;

endpackage

/* hw/rtl/tcp_active_open_close_ctrl_top.sv */
// Top level of the TCP active open/close controller.
// Instantiates tao_front, tao_cmd_fifo and tao_back; depends on tao_pkg.
//
// The block takes one input item per clock cycle while full is low and delivers one result
// per cycle while pop is high. An item is classified at acceptance; its first result is
// registered in the command queue and then in the output register before it appears on
// the result ports. Items that cause two results (a lookup hit, or a state reply that starts
// a FIN) keep the output register for their second result before the next command is taken;
// the command queue between the front and back ends (CMD_DEPTH entries) absorbs that and
// short output stalls. The local_ip register is written through the cfg channel, which is
// always ready. No clearing pass is needed after reset.
module tcp_active_open_close_ctrl_top
#(
    parameter int CMD_DEPTH = tao_pkg::CMD_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  kind,
    input  logic [31:0] remote_ip,
    input  logic [15:0] remote_port,
    input  logic        lookup_hit,
    input  logic [15:0] session_id,
    input  logic [15:0] free_port,
    input  logic        open_success,
    input  logic [3:0]  tcp_state,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  out_kind,
    output logic [31:0] out_local_ip,
    output logic [15:0] out_local_port,
    output logic [31:0] out_remote_ip,
    output logic [15:0] out_remote_port,
    output logic [15:0] out_session,
    output logic        out_success,
    output logic        event_type,
    output logic        state_write,
    output logic [3:0]  state_value,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0]           local_ip_reg;
    logic                  cmd_push;
    logic                  cmd_pop;
    logic                  cmd_full;
    logic                  cmd_empty;
    tao_pkg::cmd_t         cmd_in;
    tao_pkg::cmd_t         cmd_out;
    tao_pkg::front_status_t front_status;
    logic                  res_valid;
    tao_pkg::res_t         res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            local_ip_reg <= cfg_data;
        end
    end

    tao_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .kind         (kind),
        .remote_ip    (remote_ip),
        .remote_port  (remote_port),
        .lookup_hit   (lookup_hit),
        .session_id   (session_id),
        .free_port    (free_port),
        .open_success (open_success),
        .tcp_state    (tcp_state),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in),
        .status       (front_status)
    );

    tao_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_cmd_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    tao_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .local_ip  (local_ip_reg),
        .pop       (pop),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign full            = cmd_full;
    assign empty           = !res_valid;
    assign out_kind        = res.kind;
    assign out_local_ip    = res.local_ip;
    assign out_local_port  = res.local_port;
    assign out_remote_ip   = res.remote_ip;
    assign out_remote_port = res.remote_port;
    assign out_session     = res.session;
    assign out_success     = res.success;
    assign event_type      = res.event_type;
    assign state_write     = res.state_write;
    assign state_value     = res.state_value;
    assign last            = res.last;

`ifndef SYNTHESIS
    a_refused_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == tao_pkg::RES_REFUSED) |-> last)
        else $error("Refused result without last.");

    a_syn_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == tao_pkg::RES_EVENT && event_type == tao_pkg::EVT_SYN) |-> !last)
        else $error("SYN event marked as the final result.");

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("Command pushed into a full queue.");

    a_open_enters_port: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && kind == tao_pkg::KIND_OPEN_REQ
         && front_status.phase == tao_pkg::PH_IDLE)
        |=> (front_status.phase == tao_pkg::PH_PORT))
        else $error("Open request did not move to the free-port phase.");
`endif

endmodule

/* hw/rtl/tao_front.sv */
// Front end: accepts input items, tracks the connection phase and classifies items.
// Emits one command per item into the command queue. Depends on tao_pkg.
module tao_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [2:0]             kind,
    input  logic [31:0]            remote_ip,
    input  logic [15:0]            remote_port,
    input  logic                   lookup_hit,
    input  logic [15:0]            session_id,
    input  logic [15:0]            free_port,
    input  logic                   open_success,
    input  logic [3:0]             tcp_state,
    input  logic                   cmd_full,
    output logic                   cmd_push,
    output tao_pkg::cmd_t          cmd,
    output tao_pkg::front_status_t status
);

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [31:0] pend_ip_reg;
    logic [15:0] pend_port_reg;
    logic [15:0] close_sess_reg;
    logic        accept;

    assign accept      = push && !cmd_full;
    assign cmd_push    = accept;
    assign status.phase = phase_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        cmd.code         = tao_pkg::CMD_REFUSE;
        cmd.remote_ip    = pend_ip_reg;
        cmd.remote_port  = pend_port_reg;
        cmd.port         = free_port;
        cmd.session      = session_id;
        cmd.success      = open_success;
        cmd.state        = tcp_state;
        unique case (phase_reg)
            tao_pkg::PH_PORT:
            begin
                if (kind == tao_pkg::KIND_FREE_PORT)
                begin
                    cmd.code   = tao_pkg::CMD_LOOKUP;
                    phase_next = tao_pkg::PH_IDLE;
                end
            end
            tao_pkg::PH_CLOSE:
            begin
                cmd.session = close_sess_reg;
                if (kind == tao_pkg::KIND_STATE_REPLY)
                begin
                    cmd.code   = tao_pkg::CMD_CLOSE_WR;
                    phase_next = tao_pkg::PH_IDLE;
                end
            end
            default:
            begin
                case (kind) inside
                    tao_pkg::KIND_OPEN_REQ:
                    begin
                        cmd.code   = tao_pkg::CMD_PORT_REQ;
                        phase_next = tao_pkg::PH_PORT;
                    end
                    tao_pkg::KIND_LOOKUP_REPLY:
                    begin
                        if (lookup_hit)
                        begin
                            cmd.code = tao_pkg::CMD_SYN;
                        end
                        else
                        begin
                            cmd.code    = tao_pkg::CMD_STATUS;
                            cmd.session = 16'd0;
                            cmd.success = 1'b0;
                        end
                    end
                    tao_pkg::KIND_RX_STATUS, tao_pkg::KIND_TIMER_STATUS:
                    begin
                        cmd.code = tao_pkg::CMD_STATUS;
                    end
                    tao_pkg::KIND_CLOSE_REQ:
                    begin
                        cmd.code   = tao_pkg::CMD_CLOSE_RD;
                        phase_next = tao_pkg::PH_CLOSE;
                    end
                    default:
                    begin
                        cmd.code = tao_pkg::CMD_REFUSE;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tao_pkg::PH_IDLE;
            close_sess_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            if (phase_reg == tao_pkg::PH_IDLE && kind == tao_pkg::KIND_CLOSE_REQ)
            begin
                close_sess_reg <= session_id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == tao_pkg::PH_IDLE && kind == tao_pkg::KIND_OPEN_REQ)
        begin
            pend_ip_reg   <= remote_ip;
            pend_port_reg <= remote_port;
        end
    end

endmodule

/* hw/rtl/tao_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Register-based FIFO of tao_pkg::cmd_t entries. Depends on tao_pkg.
module tao_cmd_fifo
#(
    parameter int DEPTH = tao_pkg::CMD_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tao_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output tao_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tao_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hw/rtl/tao_back.sv */
// Back end: expands each command into one or two result items.
// Holds the output register and a second-result stage. Depends on tao_pkg.
module tao_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  tao_pkg::cmd_t cmd,
    input  logic [31:0]   local_ip,
    input  logic          pop,
    output logic          cmd_pop,
    output logic          res_valid,
    output tao_pkg::res_t res
);

    tao_pkg::res_t out_res_reg;
    tao_pkg::res_t out_res_next;
    tao_pkg::res_t second_res_reg;
    tao_pkg::res_t second_res_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          second_valid_reg;
    logic          second_valid_next;
    tao_pkg::res_t first;
    tao_pkg::res_t second;
    logic          two;
    logic          load;

    always_comb
    begin
        first  = '0;
        second = '0;
        two    = 1'b0;
        unique case (cmd.code)
            tao_pkg::CMD_PORT_REQ:
            begin
                first.kind = tao_pkg::RES_PORT_REQ;
                first.last = 1'b1;
            end
            tao_pkg::CMD_LOOKUP:
            begin
                first.kind        = tao_pkg::RES_LOOKUP_REQ;
                first.local_ip    = local_ip;
                first.local_port  = {cmd.port[7:0], cmd.port[15:8]};
                first.remote_ip   = cmd.remote_ip;
                first.remote_port = cmd.remote_port;
                first.last        = 1'b1;
            end
            tao_pkg::CMD_STATUS:
            begin
                first.kind    = tao_pkg::RES_OPEN_STATUS;
                first.session = cmd.session;
                first.success = cmd.success;
                first.last    = 1'b1;
            end
            tao_pkg::CMD_SYN:
            begin
                first.kind         = tao_pkg::RES_EVENT;
                first.session      = cmd.session;
                first.event_type   = tao_pkg::EVT_SYN;
                two                = 1'b1;
                second.kind        = tao_pkg::RES_STATE_REQ;
                second.session     = cmd.session;
                second.state_write = 1'b1;
                second.state_value = tao_pkg::ST_SYN_SENT;
                second.last        = 1'b1;
            end
            tao_pkg::CMD_CLOSE_RD:
            begin
                first.kind    = tao_pkg::RES_STATE_REQ;
                first.session = cmd.session;
                first.last    = 1'b1;
            end
            tao_pkg::CMD_CLOSE_WR:
            begin
                first.kind        = tao_pkg::RES_STATE_REQ;
                first.session     = cmd.session;
                first.state_write = 1'b1;
                if (cmd.state == tao_pkg::ST_ESTABLISHED || cmd.state == tao_pkg::ST_FIN_WAIT_1
                    || cmd.state == tao_pkg::ST_FIN_WAIT_2)
                begin
                    first.state_value = tao_pkg::ST_FIN_WAIT_1;
                    two               = 1'b1;
                    second.kind       = tao_pkg::RES_EVENT;
                    second.session    = cmd.session;
                    second.event_type = tao_pkg::EVT_FIN;
                    second.last       = 1'b1;
                end
                else
                begin
                    first.state_value = cmd.state;
                    first.last        = 1'b1;
                end
            end
            default:
            begin
                first.kind = tao_pkg::RES_REFUSED;
                first.last = 1'b1;
            end
        endcase
    end

    assign load = !out_valid_reg || pop;

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_res_next      = out_res_reg;
        second_valid_next = second_valid_reg;
        second_res_next   = second_res_reg;
        cmd_pop           = 1'b0;
        if (load)
        begin
            if (second_valid_reg)
            begin
                out_valid_next    = 1'b1;
                out_res_next      = second_res_reg;
                second_valid_next = 1'b0;
            end
            else if (cmd_valid)
            begin
                out_valid_next    = 1'b1;
                out_res_next      = first;
                second_valid_next = two;
                second_res_next   = second;
                cmd_pop           = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            second_valid_reg <= second_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg    <= out_res_next;
        second_res_reg <= second_res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

endmodule

/* tb/tcp_active_open_close_ctrl_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the TCP active open/close controller top level.
// Predicts every result transfer from the input transfers and checks them in order;
// depends on tao_pkg and tcp_active_open_close_ctrl_top.
module tcp_active_open_close_ctrl_top_test;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic        lookup_hit;
        logic [15:0] session_id;
        logic [15:0] free_port;
        logic        open_success;
        logic [3:0]  tcp_state;
    } item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  kind;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic        lookup_hit;
    logic [15:0] session_id;
    logic [15:0] free_port;
    logic        open_success;
    logic [3:0]  tcp_state;
    logic        empty;
    logic        pop;
    logic [2:0]  out_kind;
    logic [31:0] out_local_ip;
    logic [15:0] out_local_port;
    logic [31:0] out_remote_ip;
    logic [15:0] out_remote_port;
    logic [15:0] out_session;
    logic        out_success;
    logic        event_type;
    logic        state_write;
    logic [3:0]  state_value;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    logic [1:0]     ctrl_phase;
    logic [31:0]    ctrl_local_ip;
    logic [31:0]    held_remote_ip;
    logic [15:0]    held_remote_port;
    logic [15:0]    held_close_session;
    tao_pkg::res_t  outbound_msgs[$];

    int  bad_transfers = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  sender_eager = 1'b0;
    bit  receiver_eager = 1'b0;

    tcp_active_open_close_ctrl_top dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic string fmt_msg(input tao_pkg::res_t m);
        return $sformatf("kind=%0d lip=%h lport=%h rip=%h rport=%h sess=%h succ=%0d %s",
                         m.kind, m.local_ip, m.local_port, m.remote_ip, m.remote_port,
                         m.session, m.success,
                         $sformatf("evt=%0d wr=%0d val=%0d last=%0d",
                                   m.event_type, m.state_write, m.state_value, m.last));
    endfunction

    // Behavior of the controller for one accepted item; appends its result transfers.
    task automatic conn_ctrl_step(input item_t it);
        tao_pkg::res_t m;
        tao_pkg::res_t m2;
        bit            two;
        m = '0;
        m2 = '0;
        two = 1'b0;
        m.last = 1'b1;
        if (ctrl_phase == tao_pkg::PH_PORT)
        begin
            if (it.kind == tao_pkg::KIND_FREE_PORT)
            begin
                m.kind = tao_pkg::RES_LOOKUP_REQ;
                m.local_ip = ctrl_local_ip;
                m.local_port = {it.free_port[7:0], it.free_port[15:8]};
                m.remote_ip = held_remote_ip;
                m.remote_port = held_remote_port;
                ctrl_phase = tao_pkg::PH_IDLE;
            end
            else
                m.kind = tao_pkg::RES_REFUSED;
        end
        else if (ctrl_phase == tao_pkg::PH_CLOSE)
        begin
            if (it.kind == tao_pkg::KIND_STATE_REPLY)
            begin
                m.kind = tao_pkg::RES_STATE_REQ;
                m.session = held_close_session;
                m.state_write = 1'b1;
                ctrl_phase = tao_pkg::PH_IDLE;
                if (it.tcp_state inside {tao_pkg::ST_ESTABLISHED, tao_pkg::ST_FIN_WAIT_1,
                                         tao_pkg::ST_FIN_WAIT_2})
                begin
                    m.state_value = tao_pkg::ST_FIN_WAIT_1;
                    m.last = 1'b0;
                    m2.kind = tao_pkg::RES_EVENT;
                    m2.session = held_close_session;
                    m2.event_type = tao_pkg::EVT_FIN;
                    m2.last = 1'b1;
                    two = 1'b1;
                end
                else
                    m.state_value = it.tcp_state;
            end
            else
                m.kind = tao_pkg::RES_REFUSED;
        end
        else
        begin
            case (it.kind) inside
                tao_pkg::KIND_OPEN_REQ:
                begin
                    held_remote_ip = it.remote_ip;
                    held_remote_port = it.remote_port;
                    m.kind = tao_pkg::RES_PORT_REQ;
                    ctrl_phase = tao_pkg::PH_PORT;
                end
                tao_pkg::KIND_LOOKUP_REPLY:
                begin
                    if (it.lookup_hit)
                    begin
                        m.kind = tao_pkg::RES_EVENT;
                        m.session = it.session_id;
                        m.event_type = tao_pkg::EVT_SYN;
                        m.last = 1'b0;
                        m2.kind = tao_pkg::RES_STATE_REQ;
                        m2.session = it.session_id;
                        m2.state_write = 1'b1;
                        m2.state_value = tao_pkg::ST_SYN_SENT;
                        m2.last = 1'b1;
                        two = 1'b1;
                    end
                    else
                        m.kind = tao_pkg::RES_OPEN_STATUS;
                end
                tao_pkg::KIND_RX_STATUS, tao_pkg::KIND_TIMER_STATUS:
                begin
                    m.kind = tao_pkg::RES_OPEN_STATUS;
                    m.session = it.session_id;
                    m.success = it.open_success;
                end
                tao_pkg::KIND_CLOSE_REQ:
                begin
                    held_close_session = it.session_id;
                    m.kind = tao_pkg::RES_STATE_REQ;
                    m.session = it.session_id;
                    ctrl_phase = tao_pkg::PH_CLOSE;
                end
                default:
                    m.kind = tao_pkg::RES_REFUSED;
            endcase
        end
        outbound_msgs.push_back(m);
        if (two)
            outbound_msgs.push_back(m2);
    endtask

    task automatic check_msg();
        tao_pkg::res_t got;
        tao_pkg::res_t want;
        string         bad;
        got.kind = out_kind;
        got.local_ip = out_local_ip;
        got.local_port = out_local_port;
        got.remote_ip = out_remote_ip;
        got.remote_port = out_remote_port;
        got.session = out_session;
        got.success = out_success;
        got.event_type = event_type;
        got.state_write = state_write;
        got.state_value = state_value;
        got.last = last;
        if (outbound_msgs.size() == 0)
        begin
            bad_transfers++;
            if (bad_transfers <= REPORT_LIMIT)
                $display("%0t: unexpected result transfer: %s", $realtime, fmt_msg(got));
            return;
        end
        want = outbound_msgs.pop_front();
        bad = "";
        if (got.kind !== want.kind) bad = {bad, " kind"};
        if (got.local_ip !== want.local_ip) bad = {bad, " local_ip"};
        if (got.local_port !== want.local_port) bad = {bad, " local_port"};
        if (got.remote_ip !== want.remote_ip) bad = {bad, " remote_ip"};
        if (got.remote_port !== want.remote_port) bad = {bad, " remote_port"};
        if (got.session !== want.session) bad = {bad, " session"};
        if (got.success !== want.success) bad = {bad, " success"};
        if (got.event_type !== want.event_type) bad = {bad, " event_type"};
        if (got.state_write !== want.state_write) bad = {bad, " state_write"};
        if (got.state_value !== want.state_value) bad = {bad, " state_value"};
        if (got.last !== want.last) bad = {bad, " last"};
        if (bad != "")
        begin
            bad_transfers++;
            if (bad_transfers <= REPORT_LIMIT)
            begin
                $display("%0t: mismatch in%s", $realtime, bad);
                $display("    expected %s", fmt_msg(want));
                $display("    actual   %s", fmt_msg(got));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_msg();
            if (stall_left > 0)
                stall_left--;
            else if (!receiver_eager)
                stall_left = gap_len();
            pop <= (stall_left == 0);
        end
    end

    function automatic item_t rand_item(input logic [2:0] k);
        item_t it;
        it.kind = k;
        it.remote_ip = $urandom;
        it.remote_port = 16'($urandom);
        it.lookup_hit = 1'($urandom);
        it.session_id = 16'($urandom);
        it.free_port = 16'($urandom);
        it.open_success = 1'($urandom);
        it.tcp_state = 4'($urandom);
        return it;
    endfunction

    function automatic item_t noise_item();
        return rand_item(3'($urandom_range(0, 7)));
    endfunction

    function automatic item_t open_req(input logic [31:0] ip, input logic [15:0] port);
        item_t it;
        it = rand_item(tao_pkg::KIND_OPEN_REQ);
        it.remote_ip = ip;
        it.remote_port = port;
        return it;
    endfunction

    function automatic item_t free_port_msg(input logic [15:0] port);
        item_t it;
        it = rand_item(tao_pkg::KIND_FREE_PORT);
        it.free_port = port;
        return it;
    endfunction

    function automatic item_t lookup_reply(input logic hit, input logic [15:0] sess);
        item_t it;
        it = rand_item(tao_pkg::KIND_LOOKUP_REPLY);
        it.lookup_hit = hit;
        it.session_id = sess;
        return it;
    endfunction

    function automatic item_t status_msg(input logic [2:0] k, input logic [15:0] sess,
                                         input logic ok);
        item_t it;
        it = rand_item(k);
        it.session_id = sess;
        it.open_success = ok;
        return it;
    endfunction

    function automatic item_t close_req(input logic [15:0] sess);
        item_t it;
        it = rand_item(tao_pkg::KIND_CLOSE_REQ);
        it.session_id = sess;
        return it;
    endfunction

    function automatic item_t state_reply(input logic [3:0] st);
        item_t it;
        it = rand_item(tao_pkg::KIND_STATE_REPLY);
        it.tcp_state = st;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        push <= 1'b1;
        kind <= it.kind;
        remote_ip <= it.remote_ip;
        remote_port <= it.remote_port;
        lookup_hit <= it.lookup_hit;
        session_id <= it.session_id;
        free_port <= it.free_port;
        open_success <= it.open_success;
        tcp_state <= it.tcp_state;
        @(posedge clk);
        while (full)
            @(posedge clk);
        conn_ctrl_step(it);
        gap = sender_eager ? 0 : gap_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (outbound_msgs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_local_ip(input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ctrl_local_ip = value;
    endtask

    task automatic test_reset_local_ip();
        send_item(open_req(32'h0A00_0001, 16'd80));
        send_item(free_port_msg(16'hC123));
    endtask

    task automatic test_open_path();
        send_item(open_req(32'hFFFF_FFFF, 16'hFFFF));
        send_item(rand_item(tao_pkg::KIND_OPEN_REQ));
        send_item(rand_item(KIND_UNUSED));
        send_item(free_port_msg(16'h00FF));
        send_item(open_req(32'h0, 16'h0));
        send_item(free_port_msg(16'hFFFF));
        send_item(lookup_reply(1'b1, 16'hFFFF));
        send_item(lookup_reply(1'b0, 16'h5A5A));
        send_item(lookup_reply(1'b1, 16'h0000));
        send_item(status_msg(tao_pkg::KIND_RX_STATUS, 16'hFFFF, 1'b1));
        send_item(status_msg(tao_pkg::KIND_TIMER_STATUS, 16'h0000, 1'b0));
        send_item(rand_item(tao_pkg::KIND_STATE_REPLY));
        send_item(rand_item(KIND_UNUSED));
    endtask

    task automatic test_close_path();
        send_item(close_req(16'hFFFF));
        send_item(rand_item(tao_pkg::KIND_CLOSE_REQ));
        send_item(state_reply(tao_pkg::ST_ESTABLISHED));
        send_item(close_req(16'h0000));
        send_item(state_reply(tao_pkg::ST_FIN_WAIT_1));
        send_item(close_req(16'h1234));
        send_item(state_reply(tao_pkg::ST_FIN_WAIT_2));
        send_item(close_req(16'hABCD));
        send_item(state_reply(4'd0));
        send_item(close_req(16'h8001));
        send_item(state_reply(4'd15));
    endtask

    task automatic test_random_traffic(input int n_items);
        item_t it;
        int    roll;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
            begin
                sender_eager = ($urandom_range(0, 3) == 0);
                receiver_eager = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 199) == 0)
                wait_drained();
            roll = $urandom_range(0, 99);
            if (ctrl_phase == tao_pkg::PH_PORT)
                it = (roll < 85) ? free_port_msg(16'($urandom)) : noise_item();
            else if (ctrl_phase == tao_pkg::PH_CLOSE)
                it = (roll < 85) ? state_reply($urandom_range(0, 1) ?
                                               4'($urandom_range(3, 5)) : 4'($urandom))
                                 : noise_item();
            else if (roll < 25)
                it = open_req($urandom, 16'($urandom));
            else if (roll < 45)
                it = lookup_reply($urandom_range(0, 9) < 7, 16'($urandom));
            else if (roll < 55)
                it = status_msg(tao_pkg::KIND_RX_STATUS, 16'($urandom), 1'($urandom));
            else if (roll < 65)
                it = status_msg(tao_pkg::KIND_TIMER_STATUS, 16'($urandom), 1'($urandom));
            else if (roll < 90)
                it = close_req(16'($urandom));
            else
                it = noise_item();
            send_item(it);
        end
        sender_eager = 1'b0;
        receiver_eager = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        kind = '0;
        remote_ip = '0;
        remote_port = '0;
        lookup_hit = 1'b0;
        session_id = '0;
        free_port = '0;
        open_success = 1'b0;
        tcp_state = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        ctrl_phase = tao_pkg::PH_IDLE;
        ctrl_local_ip = '0;
        held_remote_ip = '0;
        held_remote_port = '0;
        held_close_session = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_local_ip();
        write_local_ip(32'hFFFF_FFFF);
        test_open_path();
        test_close_path();
        write_local_ip($urandom);
        test_random_traffic(400);
        write_local_ip(32'h0000_0000);
        test_random_traffic(400);
        write_local_ip(32'h8000_0001);
        test_random_traffic(400);

        wait_drained();
        repeat (16) @(posedge clk);
        if (outbound_msgs.size() != 0)
            bad_transfers++;
        if (bad_transfers == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tao_pkg.sv
hw/rtl/tao_front.sv
hw/rtl/tao_cmd_fifo.sv
hw/rtl/tao_back.sv
hw/rtl/tcp_active_open_close_ctrl_top.sv
tb/tcp_active_open_close_ctrl_top_test.sv
